[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Word layouts of the request and response ports, the sweep control and
// status words, command codes and character constants.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int TCW_ROWS    = 25;
   localparam int TCW_COLUMNS = 80;
   localparam int CELL_W      = 16;
   localparam int CHAR_W      = 8;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
   localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [4:0] cell_row;
      logic [6:0] cell_column;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic copy;
   } sweep_ctrl_type;

   typedef struct packed {
      logic active;
      logic done;
   } sweep_stat_type;

endpackage

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tcw_sweep.sv]
// ----------------------------------------------------------------------------
// tcw_sweep: cell store sweep engine
// Walks every cell once. In copy mode a cell takes the cell one row below
// it (the last row takes blanks); otherwise every cell takes the blank.
// Each cell's write follows its read in the next cycle, through a registered write stage.
// ----------------------------------------------------------------------------
module tcw_sweep #(
   parameter int ROWS    = tcw_pkg::TCW_ROWS,
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tcw_pkg::sweep_ctrl_type             ctrl,
   input  logic [tcw_pkg::CELL_W-1:0]          blank,
   output tcw_pkg::sweep_stat_type             status,
   output logic                                rd_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]     rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0]          rd_data,
   output logic                                wr_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]     wr_addr,
   output logic [tcw_pkg::CELL_W-1:0]          wr_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(COLUMNS);

   logic                       run_ff, run_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic                       copy_ff, copy_in;
   logic [tcw_pkg::CELL_W-1:0] blank_ff, blank_in;
   logic                       wv_ff, wv_in;
   logic [ADDR_W-1:0]          wa_ff, wa_in;
   logic                       wcopy_ff, wcopy_in;
   logic                       wlast_ff, wlast_in;
   logic                       fetch;

   assign fetch = run_ff && copy_ff && (idx_ff < COPY_END);

   always_comb begin
      run_in   = run_ff;
      idx_in   = idx_ff;
      copy_in  = copy_ff;
      blank_in = blank_ff;
      if (ctrl.start) begin
         run_in   = 1'b1;
         idx_in   = '0;
         copy_in  = ctrl.copy;
         blank_in = blank;
      end else if (run_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            run_in = 1'b0;
         end
      end
      wv_in    = run_ff;
      wa_in    = idx_ff;
      wcopy_in = fetch;
      wlast_in = (idx_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         wv_ff  <= 1'b0;
      end else begin
         run_ff <= run_in;
         wv_ff  <= wv_in;
      end
      idx_ff   <= idx_in;
      copy_ff  <= copy_in;
      blank_ff <= blank_in;
      wa_ff    <= wa_in;
      wcopy_ff <= wcopy_in;
      wlast_ff <= wlast_in;
   end

   assign rd_en   = fetch;
   assign rd_addr = idx_ff + ROW_STEP;
   assign wr_en   = wv_ff;
   assign wr_addr = wa_ff;
   assign wr_data = wcopy_ff ? rd_data : blank_ff;

   assign status.active = run_ff | wv_ff;
   assign status.done   = wv_ff & wlast_ff;

endmodule

[sv/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core: text console cell store with cursor
// Put character, read cell and clear screen on a ROWS x COLUMNS store.
// ----------------------------------------------------------------------------
// Timing: a command is taken when start is high and busy is low; its result
// word appears on rsp_data for exactly one cycle, flagged by rsp_strobe, and
// the receiver cannot stall it. A put that needs no scroll, a read and the
// unused command leave the block idle, so such commands may follow back to
// back; the result shows in the cycle after the command is taken. A put that
// finds a scroll pending (cursor row equal to ROWS) walks the whole store
// through the single read and single write port of the cell RAM, one cell a
// cycle. Clear walks the store the same way. After reset a clearing pass
// writes blanks (space, attribute 0x07) into every cell; busy stays high
// until the pass is done. The attribute register takes csr_data
// whenever csr_valid is high (csr_ready is always high, also during the
// clearing pass).
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int ROWS    = tcw_pkg::TCW_ROWS,
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam logic [ROW_W-1:0] ROW_PENDING = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]   COL_END     = (COL_W + 1)'(COLUMNS);

   typedef enum logic [5:0] {
      ST_INIT     = 6'b000001,
      ST_INIT_RUN = 6'b000010,
      ST_IDLE     = 6'b000100,
      ST_SCROLL   = 6'b001000,
      ST_CLEAR    = 6'b010000,
      ST_PUT      = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [ROW_W-1:0]            cur_row_ff, cur_row_in;
   logic [COL_W-1:0]            cur_col_ff, cur_col_in;
   logic [7:0]                  attr_ff, attr_in;
   logic [7:0]                  char_ff, char_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_read_ff, rsp_read_in;

   // command decode
   logic                        accept;
   logic                        row_over;
   logic                        in_range;
   logic                        do_put;
   logic [7:0]                  put_char;
   logic [COL_W:0]              col_sum;
   logic                        wrap;

   // cell RAM and sweep hookup
   tcw_pkg::sweep_ctrl_type     sweep_ctrl;
   tcw_pkg::sweep_stat_type     sweep_stat;
   logic [tcw_pkg::CELL_W-1:0]  sweep_blank;
   logic                        sw_rd_en, sw_wr_en;
   logic [ADDR_W-1:0]           sw_rd_addr, sw_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  sw_wr_data;
   logic                        top_rd_en, top_wr_en;
   logic [ADDR_W-1:0]           put_addr, read_addr;
   logic                        ram_rd_en, ram_wr_en;
   logic [ADDR_W-1:0]           ram_rd_addr, ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wr_data, ram_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // A cursor row equal to ROWS means the next put scrolls first.
   assign row_over = (cur_row_ff == ROW_PENDING);
   assign in_range = (8'(req_data.cell_row) < 8'(ROWS)) &&
                     (9'(req_data.cell_column) < 9'(COLUMNS));

   // After a scroll the saved character is put from row ROWS-1, column 0.
   assign put_char = (state_ff == ST_PUT) ? char_ff : req_data.char_code;
   assign do_put   = (accept && (req_data.command == tcw_pkg::CMD_PUT) && !row_over)
                     || (state_ff == ST_PUT);
   assign col_sum  = {1'b0, cur_col_ff} + 1'b1;
   assign wrap     = (col_sum == COL_END);

   // Cell addresses: row times a constant row pitch plus column.
   assign put_addr  = ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_ff);
   assign read_addr = ADDR_W'(req_data.cell_row) * ADDR_W'(COLUMNS)
                      + ADDR_W'(req_data.cell_column);

   // Reset fill uses the fixed reset blank; clear and scroll use the live attribute.
   assign sweep_blank = (state_ff == ST_INIT) ? tcw_pkg::RESET_BLANK
                                              : {attr_ff, tcw_pkg::SPACE_CODE};

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      char_in      = char_ff;
      rsp_valid_in = 1'b0;
      rsp_read_in  = 1'b0;
      top_rd_en    = 1'b0;
      top_wr_en    = 1'b0;
      sweep_ctrl   = '0;
      attr_in      = csr_valid ? csr_data : attr_ff;

      case (state_ff)
         ST_INIT: begin
            sweep_ctrl.start = 1'b1;
            state_in         = ST_INIT_RUN;
         end
         ST_INIT_RUN: begin
            if (sweep_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  tcw_pkg::CMD_PUT: begin
                     if (row_over) begin
                        // scroll first; park the cursor at the start of the last row
                        sweep_ctrl.start = 1'b1;
                        sweep_ctrl.copy  = 1'b1;
                        cur_row_in       = ROW_LAST;
                        cur_col_in       = '0;
                        char_in          = req_data.char_code;
                        state_in         = ST_SCROLL;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tcw_pkg::CMD_READ: begin
                     top_rd_en    = in_range;
                     rsp_read_in  = in_range;
                     rsp_valid_in = 1'b1;
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     sweep_ctrl.start = 1'b1;
                     state_in         = ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            if (sweep_stat.done) begin
               state_in = ST_PUT;
            end
         end
         ST_CLEAR: begin
            if (sweep_stat.done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PUT: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // write the character (a newline writes nothing), then advance the cursor
      if (do_put) begin
         if (put_char == tcw_pkg::NEWLINE_CODE) begin
            cur_col_in = '0;
            cur_row_in = cur_row_ff + 1'b1;
         end else begin
            top_wr_en = 1'b1;
            if (wrap) begin
               cur_col_in = '0;
               cur_row_in = cur_row_ff + 1'b1;
            end else begin
               cur_col_in = col_sum[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         attr_ff      <= tcw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_read_ff  <= rsp_read_in;
      end
      char_ff <= char_in;
   end

   // The sweep owns both RAM ports while it runs; otherwise the command path does.
   assign ram_rd_en   = sweep_stat.active ? sw_rd_en   : top_rd_en;
   assign ram_rd_addr = sweep_stat.active ? sw_rd_addr : read_addr;
   assign ram_wr_en   = sweep_stat.active ? sw_wr_en   : top_wr_en;
   assign ram_wr_addr = sweep_stat.active ? sw_wr_addr : put_addr;
   assign ram_wr_data = sweep_stat.active ? sw_wr_data : {attr_ff, put_char};

   tcw_sweep #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (sweep_ctrl),
      .blank   (sweep_blank),
      .status  (sweep_stat),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (sw_wr_en),
      .wr_addr (sw_wr_addr),
      .wr_data (sw_wr_data)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result word: cursor masked to the port widths, cell data only for a read
   assign rsp_strobe              = rsp_valid_ff;
   assign rsp_data.cell_data      = rsp_read_ff ? ram_rd_data : '0;
   assign rsp_data.cursor_row     = 5'(cur_row_ff);
   assign rsp_data.cursor_column  = 7'(cur_col_ff);

endmodule

[sv/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the command, result and busy ports over time.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int ROWS    = tcw_pkg::TCW_ROWS,
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tcw_pkg::req_type req_data,
   input logic             rsp_strobe,
   input tcw_pkg::rsp_type rsp_data
);

   // the clearing pass holds off commands right after reset
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   // a read answers in the next cycle
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == tcw_pkg::CMD_READ) |=> rsp_strobe)
      else $error("read result missing");

   // nonzero cell data only answers a read taken the cycle before
   a_data_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.cell_data != 16'd0) |->
      $past(start && !busy && req_data.command == tcw_pkg::CMD_READ))
      else $error("cell data without read");

   // reported cursor column stays inside the geometry; the row may also equal ROWS (scroll pending)
   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp_data.cursor_column) < COLUMNS &&
                      int'(rsp_data.cursor_row) <= ROWS))
      else $error("cursor out of range");

endmodule

bind text_console_writer_core tcw_checker #(
   .ROWS    (ROWS),
   .COLUMNS (COLUMNS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
